/* rtl/core/mmp_pkg.sv */
// ----------------------------------------------------------------------------
// mmp_pkg
// Shared types and constants of the modular matrix multiply and power engine.
// ----------------------------------------------------------------------------
package mmp_pkg;

  localparam int DIM_DEFAULT = 16;

  localparam int                MOD_W       = 14;
  localparam logic [MOD_W-1:0]  MODULUS     = 14'd10007;
  localparam int                RECIP_W     = 31;
  localparam logic [RECIP_W-1:0] RECIP      = 31'd1757988013;
  localparam int                RECIP_SHIFT = 44;
  localparam int                QUOT_W      = 17;

  localparam int NUM_MEMS = 5;

  typedef enum logic [2:0] {
    OP_LOAD_A   = 3'd0,
    OP_LOAD_B   = 3'd1,
    OP_MULTIPLY = 3'd2,
    OP_POWER    = 3'd3,
    OP_READ     = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    REG_ROWS_A     = 2'd0,
    REG_INNER_SIZE = 2'd1,
    REG_COLS_B     = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MEM_A = 3'd0,
    MEM_B = 3'd1,
    MEM_R = 3'd2,
    MEM_S = 3'd3,
    MEM_W = 3'd4
  } mem_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_FIND,
    ST_IDENT,
    ST_MUL,
    ST_COPY,
    ST_DRAIN
  } state_t;

  typedef enum logic [2:0] {
    PH_MUL,
    PH_CPA,
    PH_SQ,
    PH_MA,
    PH_CPW,
    PH_CPR
  } phase_t;

  typedef struct packed {
    logic [2:0]         operation;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [15:0] element;
    logic [30:0]        exponent;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] value;
    logic [3:0]         out_row;
    logic [3:0]         out_col;
  } res_t;

  typedef struct packed {
    logic first;
    logic last;
  } mac_tag_t;

endpackage

/* rtl/core/mmp_ram.sv */
// ----------------------------------------------------------------------------
// mmp_ram
// Matrix store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module mmp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    ra0,
  input  logic [AW-1:0]    ra1,
  output logic [WIDTH-1:0] rd0,
  output logic [WIDTH-1:0] rd1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd0 <= mem[ra0];
    rd1 <= mem[ra1];
  end

endmodule

/* rtl/core/mmp_mac.sv */
// ----------------------------------------------------------------------------
// mmp_mac
// Shared multiply, modulo reduce and accumulate pipeline, one term a cycle.
// ----------------------------------------------------------------------------
module mmp_mac
  import mmp_pkg::*;
#(
  parameter int AW = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  mac_tag_t           in_tag,
  input  logic [AW-1:0]      in_addr,
  input  logic signed [15:0] x,
  input  logic signed [15:0] y,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output logic [MOD_W-1:0]   wr_data,
  output logic               busy
);

  logic               v1, v2, v3;
  logic signed [31:0] p1;
  mac_tag_t           t1, t2, t3;
  logic [AW-1:0]      a1, a2, a3;

  logic [RECIP_W-1:0] ap2;
  logic               neg2;
  logic [QUOT_W-1:0]  q2;

  logic [MOD_W-1:0]   r3;
  logic [MOD_W-1:0]   acc;

  logic signed [31:0]           abs_p;
  logic [RECIP_W-1:0]           abs_u;
  logic [2*RECIP_W-1:0]         qprod;
  logic [RECIP_W-1:0]           qm;
  logic [RECIP_W-1:0]           raw;
  logic [RECIP_W-1:0]           fixd;
  logic [MOD_W-1:0]             rmag;
  logic [MOD_W-1:0]             rterm;
  logic [MOD_W-1:0]             base;
  logic [MOD_W:0]               sum;
  logic [MOD_W-1:0]             acc_next;

  always_comb begin
    abs_p = p1[31] ? -p1 : p1;
    abs_u = abs_p[RECIP_W-1:0];
    qprod = abs_u * RECIP;
  end

  always_comb begin
    qm    = RECIP_W'(q2) * RECIP_W'(MODULUS);
    raw   = ap2 - qm;
    fixd  = (raw >= RECIP_W'(MODULUS)) ? raw - RECIP_W'(MODULUS) : raw;
    rmag  = fixd[MOD_W-1:0];
    rterm = (neg2 && rmag != '0) ? MODULUS - rmag : rmag;
  end

  always_comb begin
    base     = t3.first ? '0 : acc;
    sum      = {1'b0, base} + {1'b0, r3};
    acc_next = (sum >= {1'b0, MODULUS}) ? MOD_W'(sum - {1'b0, MODULUS}) : sum[MOD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      wr_en <= 1'b0;
    end else begin
      v1    <= in_valid;
      v2    <= v1;
      v3    <= v2;
      wr_en <= v3 && t3.last;
    end
  end

  always_ff @(posedge clk) begin
    p1   <= x * y;
    t1   <= in_tag;
    a1   <= in_addr;
    ap2  <= abs_u;
    neg2 <= p1[31];
    q2   <= qprod[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT];
    t2   <= t1;
    a2   <= a1;
    r3   <= rterm;
    t3   <= t2;
    a3   <= a2;
    wr_addr <= a3;
    if (v3) begin
      acc <= acc_next;
    end
  end

  assign wr_data = acc;
  assign busy    = v1 || v2 || v3 || wr_en;

endmodule

/* rtl/core/modular_matrix_multiply_power.sv */
// Flow: a load writes one element; a read returns the addressed word through
// the read state; a multiply issues its terms, then drains; a power copies A,
// then per lower exponent bit squares and multiplies by A or copies, then to R.
// Throughput: one term per cycle through the shared multiply/reduce unit,
// one command at a time. Synchronous active-high reset clears control and
// sets the size registers to 1; the matrix stores are not cleared.
// ----------------------------------------------------------------------------
// modular_matrix_multiply_power
// Modular (10007) matrix multiply and matrix power engine with a sequencer
// driving one shared multiply-accumulate pipeline over five matrix stores.
// ----------------------------------------------------------------------------
module modular_matrix_multiply_power
  import mmp_pkg::*;
#(
  parameter int DIM = DIM_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_stall,
  input  cmd_t       cmd,
  output logic       res_valid,
  input  logic       res_stall,
  output res_t       res,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [4:0] cfg_data
);

  localparam int CW    = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int DEPTH = DIM * DIM;
  localparam int AW    = (DIM > 1) ? $clog2(DEPTH) : 1;

  function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] r, input logic [CW-1:0] c);
    return AW'(AW'(r) * AW'(DIM)) + AW'(c);
  endfunction

  function automatic logic [CW-1:0] size_m1(input logic [4:0] v);
    if (v == 5'd0) return '0;
    if (int'(v) > DIM) return CW'(DIM - 1);
    return CW'(v - 5'd1);
  endfunction

  state_t   state, state_next;
  phase_t   phase, phase_next;
  mem_sel_t xsel, xsel_next, ysel, ysel_next, dsel, dsel_next;

  logic [4:0]    rows_a, inner_size, cols_b;
  logic [CW-1:0] i, i_next, j, j_next, k, k_next;
  logic [CW-1:0] lim_i, lim_i_next, lim_j, lim_j_next, lim_k, lim_k_next;
  logic [4:0]    bitp, bitp_next;
  logic [30:0]   expo, expo_next;
  logic [AW-1:0] rd_addr, rd_addr_next;
  logic          rd_inside, rd_inside_next;
  logic [3:0]    rd_row, rd_row_next, rd_col, rd_col_next;

  logic          iss_valid, iss_valid_next, iss_copy, iss_copy_next;
  mac_tag_t      iss_tag, iss_tag_next;
  logic [AW-1:0] iss_waddr, iss_waddr_next;

  logic          res_valid_next;
  res_t          res_next;

  logic          launch;
  phase_t        launch_ph;

  logic          accept, in_range;
  logic [AW-1:0] cmd_addr;
  logic [AW-1:0] ra0, ra1, waddr;
  logic          wen;
  mem_sel_t      wsel;
  logic [15:0]   wdata;
  logic [15:0]   rd0 [NUM_MEMS];
  logic [15:0]   rd1 [NUM_MEMS];

  logic             mac_wr_en, mac_busy;
  logic [AW-1:0]    mac_wr_addr;
  logic [MOD_W-1:0] mac_wr_data;

  assign accept    = cmd_valid && !cmd_stall;
  assign cmd_stall = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);
  assign in_range  = (7'(cmd.row) < 7'(DIM)) && (7'(cmd.col) < 7'(DIM));
  assign cmd_addr  = AW'(AW'(cmd.row) * AW'(DIM)) + AW'(cmd.col);

  for (genvar g = 0; g < NUM_MEMS; g++) begin : g_mem
    mmp_ram #(.WIDTH(16), .DEPTH(DEPTH), .AW(AW)) u_ram (
      .clk   (clk),
      .we    (wen && (wsel == mem_sel_t'(g))),
      .waddr (waddr),
      .wdata (wdata),
      .ra0   (ra0),
      .ra1   (ra1),
      .rd0   (rd0[g]),
      .rd1   (rd1[g])
    );
  end

  mmp_mac #(.AW(AW)) u_mac (
    .clk      (clk),
    .rst      (rst),
    .in_valid (iss_valid && !iss_copy),
    .in_tag   (iss_tag),
    .in_addr  (iss_waddr),
    .x        (rd0[xsel]),
    .y        (rd1[ysel]),
    .wr_en    (mac_wr_en),
    .wr_addr  (mac_wr_addr),
    .wr_data  (mac_wr_data),
    .busy     (mac_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      phase      <= PH_MUL;
      iss_valid  <= 1'b0;
      res_valid  <= 1'b0;
      rows_a     <= 5'd1;
      inner_size <= 5'd1;
      cols_b     <= 5'd1;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      iss_valid <= iss_valid_next;
      res_valid <= res_valid_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_ROWS_A:     rows_a     <= cfg_data;
          REG_INNER_SIZE: inner_size <= cfg_data;
          REG_COLS_B:     cols_b     <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    xsel      <= xsel_next;
    ysel      <= ysel_next;
    dsel      <= dsel_next;
    i         <= i_next;
    j         <= j_next;
    k         <= k_next;
    lim_i     <= lim_i_next;
    lim_j     <= lim_j_next;
    lim_k     <= lim_k_next;
    bitp      <= bitp_next;
    expo      <= expo_next;
    rd_addr   <= rd_addr_next;
    rd_inside <= rd_inside_next;
    rd_row    <= rd_row_next;
    rd_col    <= rd_col_next;
    iss_copy  <= iss_copy_next;
    iss_tag   <= iss_tag_next;
    iss_waddr <= iss_waddr_next;
    res       <= res_next;
  end

  always_comb begin
    state_next     = state;
    phase_next     = phase;
    xsel_next      = xsel;
    ysel_next      = ysel;
    dsel_next      = dsel;
    i_next         = i;
    j_next         = j;
    k_next         = k;
    lim_i_next     = lim_i;
    lim_j_next     = lim_j;
    lim_k_next     = lim_k;
    bitp_next      = bitp;
    expo_next      = expo;
    rd_addr_next   = rd_addr;
    rd_inside_next = rd_inside;
    rd_row_next    = rd_row;
    rd_col_next    = rd_col;
    iss_valid_next = 1'b0;
    iss_copy_next  = 1'b0;
    iss_tag_next   = '0;
    iss_waddr_next = iss_waddr;
    res_valid_next = res_valid && res_stall;
    res_next       = res;
    launch         = 1'b0;
    launch_ph      = phase;
    ra0            = addr_of(i, j);
    ra1            = addr_of(k, j);
    wen            = 1'b0;
    wsel           = dsel;
    waddr          = mac_wr_addr;
    wdata          = {2'b00, mac_wr_data};

    // pipeline and copy write back
    if (mac_wr_en) begin
      wen = 1'b1;
    end else if (iss_valid && iss_copy) begin
      wen   = 1'b1;
      waddr = iss_waddr;
      wdata = rd0[xsel];
    end

    unique case (state)
      ST_IDLE: begin
        ra0 = cmd_addr;
        if (accept) begin
          case (cmd.operation)
            OP_LOAD_A, OP_LOAD_B: begin
              if (in_range) begin
                wen   = 1'b1;
                wsel  = (cmd.operation == OP_LOAD_A) ? MEM_A : MEM_B;
                waddr = cmd_addr;
                wdata = cmd.element;
              end
            end
            OP_MULTIPLY: begin
              lim_i_next = size_m1(rows_a);
              lim_k_next = size_m1(inner_size);
              lim_j_next = size_m1(cols_b);
              launch     = 1'b1;
              launch_ph  = PH_MUL;
            end
            OP_POWER: begin
              lim_i_next = size_m1(rows_a);
              lim_k_next = size_m1(rows_a);
              lim_j_next = size_m1(rows_a);
              expo_next  = cmd.exponent;
              bitp_next  = 5'd30;
              i_next     = '0;
              j_next     = '0;
              state_next = (cmd.exponent == '0) ? ST_IDENT : ST_FIND;
            end
            OP_READ: begin
              rd_addr_next   = cmd_addr;
              rd_inside_next = in_range;
              rd_row_next    = cmd.row;
              rd_col_next    = cmd.col;
              state_next     = ST_READ;
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        ra0 = rd_addr;
        if (!res_valid || !res_stall) begin
          res_valid_next   = 1'b1;
          res_next.value   = rd_inside ? rd0[MEM_R] : '0;
          res_next.out_row = rd_row;
          res_next.out_col = rd_col;
          state_next       = ST_IDLE;
        end
      end
      ST_FIND: begin
        if (bitp != 5'd0 && !expo[bitp]) begin
          bitp_next = bitp - 5'd1;
        end else begin
          launch    = 1'b1;
          launch_ph = PH_CPA;
        end
      end
      ST_IDENT: begin
        wen   = 1'b1;
        wsel  = MEM_R;
        waddr = addr_of(i, j);
        wdata = (i == j) ? 16'd1 : 16'd0;
        if (j == lim_j) begin
          j_next = '0;
          if (i == lim_i) begin
            state_next = ST_IDLE;
          end else begin
            i_next = i + 1'b1;
          end
        end else begin
          j_next = j + 1'b1;
        end
      end
      ST_MUL: begin
        ra0                = addr_of(i, k);
        ra1                = addr_of(k, j);
        iss_valid_next     = 1'b1;
        iss_tag_next.first = (k == '0);
        iss_tag_next.last  = (k == lim_k);
        iss_waddr_next     = addr_of(i, j);
        if (k == lim_k) begin
          k_next = '0;
          if (j == lim_j) begin
            j_next = '0;
            if (i == lim_i) begin
              state_next = ST_DRAIN;
            end else begin
              i_next = i + 1'b1;
            end
          end else begin
            j_next = j + 1'b1;
          end
        end else begin
          k_next = k + 1'b1;
        end
      end
      ST_COPY: begin
        ra0            = addr_of(i, j);
        iss_valid_next = 1'b1;
        iss_copy_next  = 1'b1;
        iss_waddr_next = addr_of(i, j);
        if (j == lim_j) begin
          j_next = '0;
          if (i == lim_i) begin
            state_next = ST_DRAIN;
          end else begin
            i_next = i + 1'b1;
          end
        end else begin
          j_next = j + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!iss_valid && !mac_busy) begin
          unique case (phase)
            PH_MUL, PH_CPR: state_next = ST_IDLE;
            PH_SQ: begin
              launch    = 1'b1;
              launch_ph = expo[bitp] ? PH_MA : PH_CPW;
            end
            PH_CPA, PH_MA, PH_CPW: begin
              launch = 1'b1;
              if (bitp == 5'd0) begin
                launch_ph = PH_CPR;
              end else begin
                bitp_next = bitp - 5'd1;
                launch_ph = PH_SQ;
              end
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      default: state_next = ST_IDLE;
    endcase

    if (launch) begin
      phase_next = launch_ph;
      i_next     = '0;
      j_next     = '0;
      k_next     = '0;
      unique case (launch_ph)
        PH_MUL: begin
          xsel_next = MEM_A; ysel_next = MEM_B; dsel_next = MEM_R; state_next = ST_MUL;
        end
        PH_CPA: begin
          xsel_next = MEM_A; dsel_next = MEM_S; state_next = ST_COPY;
        end
        PH_SQ: begin
          xsel_next = MEM_S; ysel_next = MEM_S; dsel_next = MEM_W; state_next = ST_MUL;
        end
        PH_MA: begin
          xsel_next = MEM_W; ysel_next = MEM_A; dsel_next = MEM_S; state_next = ST_MUL;
        end
        PH_CPW: begin
          xsel_next = MEM_W; dsel_next = MEM_S; state_next = ST_COPY;
        end
        PH_CPR: begin
          xsel_next = MEM_S; dsel_next = MEM_R; state_next = ST_COPY;
        end
        default: state_next = ST_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/mmp_checker.sv */
// ----------------------------------------------------------------------------
// mmp_checker
// Port-level checks of the matrix engine, bound to the top level.
// ----------------------------------------------------------------------------
module mmp_checker
  import mmp_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       cmd_valid,
  input logic       cmd_stall,
  input cmd_t       cmd,
  input logic       res_valid,
  input logic       res_stall,
  input res_t       res,
  input logic       cfg_valid,
  input logic       cfg_ready,
  input logic [1:0] cfg_index,
  input logic [4:0] cfg_data
);

  logic cmd_acc;
  assign cmd_acc = cmd_valid && !cmd_stall;

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result word changed while stalled");

  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_ready == !cmd_stall)
    else $error("config port open while busy");

  a_busy_after_op: assert property (@(posedge clk) disable iff (rst)
    cmd_acc && (cmd.operation == OP_MULTIPLY || cmd.operation == OP_POWER ||
                cmd.operation == OP_READ) |=> cmd_stall)
    else $error("engine idle right after a long command");

  a_read_echo: assert property (@(posedge clk) disable iff (rst)
    cmd_acc && cmd.operation == OP_READ && !res_valid |-> ##2
      (res_valid && res.out_row == $past(cmd.row, 2) && res.out_col == $past(cmd.col, 2)))
    else $error("read word late or with wrong position");

endmodule

bind modular_matrix_multiply_power mmp_checker u_mmp_checker (.*);
